[sv/xsph_pkg.sv]
// Package for the XSPH velocity smoothing block.
// Holds item types, the particle record, FSM state codes and kind and register codes.
// No dependencies.
package xsph_pkg;

  localparam int IDX_W = 12;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [IDX_W-1:0]  particle_index;
    logic [IDX_W-1:0]  neighbor_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   out_index;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
  } out_item_t;

  // One stored particle: position and velocity per axis, axis 0 is x
  typedef struct packed {
    word_t [2:0] vel;
    word_t [2:0] pos;
  } part_t;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_NEIGH  = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;
  localparam logic [1:0] KIND_SPARE  = 2'd3;

  localparam logic [1:0] CFG_GAIN      = 2'd0;
  localparam logic [1:0] CFG_RADIUS_SQ = 2'd1;
  localparam logic [1:0] CFG_INV_RSQ   = 2'd2;

  localparam logic [1:0] AXIS_LAST = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SLOT0,
    ST_SLOT1,
    ST_ISSUE,
    ST_SQ,
    ST_CMP,
    ST_WMUL,
    ST_Q,
    ST_CUBE,
    ST_ACC,
    ST_DIVST,
    ST_DIVW,
    ST_GAIN,
    ST_ADD,
    ST_EMIT
  } state_t;

endpackage

[sv/xsph_mem.sv]
// Particle store: one write port and two registered read ports.
// Depends on xsph_pkg for the particle record type.
module xsph_mem import xsph_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  part_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output part_t         rdata_a,
  output part_t         rdata_b
);

  part_t mem [DEPTH];

  // Write a loaded particle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read both ports, hold data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[sv/xsph_div.sv]
// Restoring divider, one quotient bit per cycle: 64-bit dividend by 32-bit divisor.
// Depends on xsph_pkg only for house consistency of types.
module xsph_div import xsph_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  word_t       divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [63:0] dvd;
  word_t       dsr;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        ge;

  // Shift one dividend bit into the remainder and try a subtract
  always_comb begin
    rem_sh  = {rem, dvd[63]};
    rem_sub = rem_sh - {1'b0, dsr};
    ge      = rem_sh >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvd  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
        dvd <= {dvd[62:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = dvd;

endmodule

[sv/xsph_velocity_smoothing.sv]
// XSPH velocity smoothing with a normalized Poly6 weight, Q16.16 fixed point.
// Input channel in_valid/in_ready/in_item carries one item at a time; kind 0
// loads a particle into the store, kind 1 adds one neighbor to the running sums,
// kind 2 emits the smoothed velocity of the named particle and clears the sums.
// Output channel out_valid/out_ready/out_item carries one item per kind 2 item.
// Configuration: cfg_we writes cfg_data into register cfg_index at once
// (0 gain, 1 radius squared, 2 reciprocal of radius squared); write while idle.
// Steps per item, set by the sequencer around the particle memory:
//   kind 0: index reduction, then one memory write
//   kind 1: two-port read, three squares, four partial products of the
//           radius ratio, cube, three weighted adds; it ends after the read
//           for the particle itself and after the compare outside the radius,
//           and is taken and dropped once the neighbor bound is reached
//   kind 2: bit-serial divide on each of three axes, skipped at zero weight sum
//   kind 3: dropped
// The result sits in an output register; the next item is taken while it
// waits, and a later kind 2 item holds in its last step until it is taken.
// Reset clears the sums, the neighbor count, the registers and both channels;
// the particle memory is not cleared and must be loaded before it is read.
module xsph_velocity_smoothing import xsph_pkg::*; #(
  parameter int MAX_PARTICLES  = 4096,
  parameter int NEIGHBOR_BOUND = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [61:0] cfg_data
);

  localparam int AW    = $clog2(MAX_PARTICLES);
  localparam int NCW   = $clog2(NEIGHBOR_BOUND + 1);
  localparam int RECIP = (1 << 24) / MAX_PARTICLES;
  localparam logic [23:0]    RECIP_C = RECIP[23:0];
  localparam logic [28:0]    MAX_C   = 29'(MAX_PARTICLES);
  localparam logic [NCW-1:0] NB_C    = NCW'(NEIGHBOR_BOUND);

  // Reduce a raw index below the store depth from its estimated quotient
  function automatic logic [AW-1:0] slot_of(logic [IDX_W-1:0] idx, logic [IDX_W-1:0] q);
    logic [28:0] r;
    r = 29'(idx) - 29'(q) * MAX_C;
    if (r >= MAX_C) r = r - MAX_C;
    return r[AW-1:0];
  endfunction

  // Configuration
  logic [17:0] gain;
  logic [61:0] radius_sq;
  logic [47:0] inv_rsq;

  // Control
  state_t state, state_next;
  logic [NCW-1:0] nb_count;
  logic [1:0]     axis;
  logic [1:0]     part;

  // Item registers
  in_item_t         item;
  logic [IDX_W-1:0] qp, qn;
  logic [AW-1:0]    slot_p, slot_n;

  // Datapath registers
  logic [63:0]  r2;
  logic [61:0]  rgap;
  logic [109:0] acc;
  logic [15:0]  q;
  logic [31:0]  q2;
  logic [15:0]  w;
  logic [2:0][63:0] csum;
  logic [31:0]  wtot;
  logic signed [33:0] corr;
  logic signed [52:0] gprod;
  word_t [2:0]  nvel;
  out_item_t    out_reg;
  logic         out_full;

  // Memory and divider wiring
  logic  mem_we, mem_re;
  part_t wr_rec, rd_p, rd_n;
  logic  div_start, div_done;
  logic [63:0] div_quo, div_dvd;

  // Combinational datapath terms
  logic [32:0]  pdiff;
  logic [31:0]  pabs;
  logic [63:0]  sq;
  logic [64:0]  r2_sum;
  logic [31:0]  opa, opb;
  logic [63:0]  pp;
  logic [109:0] pp_sh;
  logic [47:0]  cube;
  logic signed [32:0] vdiff;
  logic signed [49:0] vprod;
  logic signed [36:0] adj;
  logic signed [37:0] vsum;
  word_t        vsat;
  logic [35:0]  qprod_p, qprod_n;
  logic         accept, emit_ok;

  assign accept  = in_valid && in_ready;
  assign emit_ok = !out_full || out_ready;

  assign wr_rec = {item.vel_z, item.vel_y, item.vel_x, item.pos_z, item.pos_y, item.pos_x};

  xsph_mem #(.DEPTH(MAX_PARTICLES), .AW(AW)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (slot_p),
    .wdata   (wr_rec),
    .re      (mem_re),
    .raddr_a (slot_p),
    .raddr_b (slot_n),
    .rdata_a (rd_p),
    .rdata_b (rd_n)
  );

  xsph_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (wtot),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Arithmetic terms of the current step
  always_comb begin
    qprod_p = 36'(item.particle_index) * 36'(RECIP_C);
    qprod_n = 36'(item.neighbor_index) * 36'(RECIP_C);
    pdiff   = {rd_p.pos[axis][31], rd_p.pos[axis]} - {rd_n.pos[axis][31], rd_n.pos[axis]};
    pabs    = pdiff[32] ? 32'(-pdiff) : pdiff[31:0];
    sq      = 64'(pabs) * 64'(pabs);
    r2_sum  = {1'b0, r2} + {1'b0, sq};
    case (part)
      2'd0: begin opa = rgap[31:0];         opb = inv_rsq[31:0];        end
      2'd1: begin opa = rgap[31:0];         opb = {16'b0, inv_rsq[47:32]}; end
      2'd2: begin opa = {2'b0, rgap[61:32]}; opb = inv_rsq[31:0];        end
      default: begin opa = {2'b0, rgap[61:32]}; opb = {16'b0, inv_rsq[47:32]}; end
    endcase
    pp = 64'(opa) * 64'(opb);
    case (part)
      2'd0:    pp_sh = 110'(pp);
      2'd3:    pp_sh = 110'(pp) << 64;
      default: pp_sh = 110'(pp) << 32;
    endcase
    cube  = 48'(q2) * 48'(q);
    vdiff = $signed({rd_n.vel[axis][31], rd_n.vel[axis]}) -
            $signed({rd_p.vel[axis][31], rd_p.vel[axis]});
    vprod = vdiff * $signed({1'b0, w});
    div_dvd = csum[axis][63] ? (~csum[axis] + 64'd1) : csum[axis];
    adj   = gprod[52:16];
    vsum  = $signed({{6{rd_p.vel[axis][31]}}, rd_p.vel[axis]}) + 38'(adj);
    if (vsum > 38'sd2147483647)       vsat = 32'h7fff_ffff;
    else if (vsum < -38'sd2147483648) vsat = 32'h8000_0000;
    else                              vsat = vsum[31:0];
  end

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Sequence the steps of each kind
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_item.kind == KIND_LOAD || in_item.kind == KIND_FINISH ||
              (in_item.kind == KIND_NEIGH && nb_count < NB_C)) begin
            state_next = ST_SLOT0;
          end
        end
      end
      ST_SLOT0: state_next = ST_SLOT1;
      ST_SLOT1: state_next = ST_ISSUE;
      ST_ISSUE: begin
        case (item.kind)
          KIND_LOAD: begin
            mem_we     = 1'b1;
            state_next = ST_IDLE;
          end
          KIND_NEIGH: begin
            if (slot_p == slot_n) begin
              state_next = ST_IDLE;
            end else begin
              mem_re     = 1'b1;
              state_next = ST_SQ;
            end
          end
          default: begin
            mem_re     = 1'b1;
            state_next = ST_DIVST;
          end
        endcase
      end
      ST_SQ:   if (axis == AXIS_LAST) state_next = ST_CMP;
      ST_CMP:  state_next = (r2 > {2'b0, radius_sq}) ? ST_IDLE : ST_WMUL;
      ST_WMUL: if (part == 2'd3) state_next = ST_Q;
      ST_Q:    state_next = ST_CUBE;
      ST_CUBE: state_next = ST_ACC;
      ST_ACC:  if (axis == AXIS_LAST) state_next = ST_IDLE;
      ST_DIVST: begin
        if (wtot == '0) begin
          state_next = ST_GAIN;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIVW;
        end
      end
      ST_DIVW: if (div_done) state_next = ST_GAIN;
      ST_GAIN: state_next = ST_ADD;
      ST_ADD:  state_next = (axis == AXIS_LAST) ? ST_EMIT : ST_DIVST;
      ST_EMIT: if (emit_ok) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers: configuration, neighbor count, sums, output
  always_ff @(posedge clk) begin
    if (rst) begin
      gain      <= '0;
      radius_sq <= '0;
      inv_rsq   <= '0;
      nb_count  <= '0;
      csum      <= '0;
      wtot      <= '0;
      out_full  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN:      gain      <= cfg_data[17:0];
          CFG_RADIUS_SQ: radius_sq <= cfg_data;
          CFG_INV_RSQ:   inv_rsq   <= cfg_data[47:0];
          default: ;
        endcase
      end
      // Count every neighbor item under the bound, skipped ones too
      if (accept && in_item.kind == KIND_NEIGH && nb_count < NB_C) begin
        nb_count <= nb_count + NCW'(1);
      end
      if (state == ST_ACC) begin
        csum[axis] <= csum[axis] + 64'(vprod);
        if (axis == AXIS_LAST) wtot <= wtot + 32'(w);
      end
      // Emit and clear the sums for the next particle
      if (state == ST_EMIT && emit_ok) begin
        out_full <= 1'b1;
        csum     <= '0;
        wtot     <= '0;
        nb_count <= '0;
      end else if (out_full && out_ready) begin
        out_full <= 1'b0;
      end
    end
  end

  // Step counter over axes and partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      axis <= '0;
      part <= '0;
    end else begin
      case (state)
        ST_ISSUE: begin
          axis <= '0;
          part <= '0;
        end
        ST_SQ:   axis <= (axis == AXIS_LAST) ? 2'd0 : axis + 2'd1;
        ST_WMUL: part <= part + 2'd1;
        ST_ACC:  axis <= axis + 2'd1;
        ST_ADD:  axis <= axis + 2'd1;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) item <= in_item;
    case (state)
      ST_SLOT0: begin
        qp <= qprod_p[35:24];
        qn <= qprod_n[35:24];
      end
      ST_SLOT1: begin
        slot_p <= slot_of(item.particle_index, qp);
        slot_n <= slot_of(item.neighbor_index, qn);
      end
      ST_ISSUE: r2 <= '0;
      ST_SQ:    r2 <= r2_sum[64] ? '1 : r2_sum[63:0];
      ST_CMP: begin
        rgap <= radius_sq - r2[61:0];
        acc  <= '0;
      end
      ST_WMUL: acc <= acc + pp_sh;
      ST_Q: begin
        q  <= (acc[109:64] != '0) ? 16'hffff : acc[63:48];
        q2 <= (acc[109:64] != '0) ? 32'(17'h1_0000 - 17'd1) * 32'hffff :
                                    32'(acc[63:48]) * 32'(acc[63:48]);
      end
      ST_CUBE:  w <= cube[47:32];
      ST_DIVST: corr <= '0;
      ST_DIVW: begin
        if (div_done) begin
          corr <= csum[axis][63] ? -$signed({1'b0, div_quo[32:0]})
                                 :  $signed({1'b0, div_quo[32:0]});
        end
      end
      ST_GAIN: gprod <= $signed({1'b0, gain}) * corr;
      ST_ADD:  nvel[axis] <= vsat;
      default: ;
    endcase
    if (state == ST_EMIT && emit_ok) begin
      out_reg.out_index <= item.particle_index;
      out_reg.new_vel_x <= nvel[0];
      out_reg.new_vel_y <= nvel[1];
      out_reg.new_vel_z <= nvel[2];
    end
  end

  assign out_valid = out_full;
  assign out_item  = out_reg;

endmodule

[tb/xsph_smoothing_checker.sv]
// Checker for the XSPH velocity smoothing block: watches both channels and the
// configuration port, predicts each smoothed velocity and compares it.
// Depends on xsph_pkg for the item types and the kind and register codes.
module xsph_smoothing_checker import xsph_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [61:0] cfg_data,
  output int          errors,
  output int          pending
);

  localparam int NB_LIMIT = 64;

  // particle snapshot as seen by the block
  logic signed [31:0] px [4096];
  logic signed [31:0] py [4096];
  logic signed [31:0] pz [4096];
  logic signed [31:0] vx [4096];
  logic signed [31:0] vy [4096];
  logic signed [31:0] vz [4096];

  longint      sum_x, sum_y, sum_z;
  logic [63:0] wt_sum;
  int          nb_seen;

  logic [17:0] gain_r;
  logic [61:0] rsq_r;
  logic [47:0] inv_r;

  out_item_t expected_vel_q[$];

  initial errors = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH t=%0t: %s", $time, what);
    errors++;
  endtask

  function automatic logic [65:0] axis_sq(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
    logic signed [32:0] d;
    logic [65:0]        m;
    d = {a[31], a} - {b[31], b};
    m = (d < 0) ? 66'(-d) : 66'(d);
    return m * m;
  endfunction

  function automatic logic [63:0] sat64(input logic [65:0] v);
    return (v > 66'hFFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : v[63:0];
  endfunction

  // Poly6 weight of one neighbor, or -1 when it lies outside the radius
  function automatic int neighbor_weight(input int p, input int n);
    logic [63:0]  r2;
    logic [109:0] dd, ii, pr;
    logic [15:0]  q;
    logic [47:0]  q3;
    r2 = sat64(66'(sat64(axis_sq(px[p], px[n]) + axis_sq(py[p], py[n])))
               + axis_sq(pz[p], pz[n]));
    if (r2 > {2'b00, rsq_r}) return -1;
    dd = 110'(rsq_r - r2[61:0]);
    ii = 110'(inv_r);
    pr = dd * ii;
    q = (pr[109:64] != 0) ? 16'hFFFF : pr[63:48];
    q3 = 48'(q) * 48'(q) * 48'(q);
    return int'(q3[47:32]);
  endfunction

  function automatic logic signed [31:0] smooth_axis(input logic signed [31:0] v,
                                                     input longint s);
    longint corr, prod, r;
    corr = (wt_sum != 0) ? s / longint'(wt_sum) : 0;
    prod = longint'({46'd0, gain_r}) * corr;
    r = longint'(v) + (prod >>> 16);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  task automatic clear_sums();
    sum_x = 0; sum_y = 0; sum_z = 0; wt_sum = 0; nb_seen = 0;
  endtask

  // Advance the prediction by one accepted item
  task automatic predict_item(input in_item_t it);
    int        p, n, w;
    out_item_t r;
    p = it.particle_index;
    n = it.neighbor_index;
    case (it.kind)
      KIND_LOAD: begin
        px[p] = it.pos_x; py[p] = it.pos_y; pz[p] = it.pos_z;
        vx[p] = it.vel_x; vy[p] = it.vel_y; vz[p] = it.vel_z;
      end
      KIND_NEIGH: begin
        if (nb_seen < NB_LIMIT) begin
          nb_seen++;
          if (n != p) begin
            w = neighbor_weight(p, n);
            if (w >= 0) begin
              sum_x += (longint'(vx[n]) - longint'(vx[p])) * longint'(w);
              sum_y += (longint'(vy[n]) - longint'(vy[p])) * longint'(w);
              sum_z += (longint'(vz[n]) - longint'(vz[p])) * longint'(w);
              wt_sum += 64'(w);
            end
          end
        end
      end
      KIND_FINISH: begin
        r.out_index = it.particle_index;
        r.new_vel_x = smooth_axis(vx[p], sum_x);
        r.new_vel_y = smooth_axis(vy[p], sum_y);
        r.new_vel_z = smooth_axis(vz[p], sum_z);
        expected_vel_q.push_back(r);
        clear_sums();
      end
      default: ;
    endcase
  endtask

  // Compare results, then fold in inputs and register writes
  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      expected_vel_q.delete();
      clear_sums();
      gain_r = '0; rsq_r = '0; inv_r = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_vel_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result for index %0d", out_item.out_index));
        end else begin
          e = expected_vel_q.pop_front();
          if (out_item.out_index !== e.out_index)
            report_mismatch($sformatf("out_index %0d, want %0d",
                                      out_item.out_index, e.out_index));
          if (out_item.new_vel_x !== e.new_vel_x)
            report_mismatch($sformatf("new_vel_x %0d, want %0d",
                                      out_item.new_vel_x, e.new_vel_x));
          if (out_item.new_vel_y !== e.new_vel_y)
            report_mismatch($sformatf("new_vel_y %0d, want %0d",
                                      out_item.new_vel_y, e.new_vel_y));
          if (out_item.new_vel_z !== e.new_vel_z)
            report_mismatch($sformatf("new_vel_z %0d, want %0d",
                                      out_item.new_vel_z, e.new_vel_z));
        end
      end
      if (in_valid && in_ready) predict_item(in_item);
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN:      gain_r = cfg_data[17:0];
          CFG_RADIUS_SQ: rsq_r = cfg_data;
          CFG_INV_RSQ:   inv_r = cfg_data[47:0];
          default: ;
        endcase
      end
    end
    pending = expected_vel_q.size();
  end

endmodule

[tb/xsph_velocity_smoothing_tb.sv]
// Top of the XSPH velocity smoothing testbench: clock, reset, stimulus and verdict.
// Depends on xsph_pkg, the block xsph_velocity_smoothing and xsph_smoothing_checker.
module xsph_velocity_smoothing_tb;
  import xsph_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [61:0] cfg_data = '0;

  int   errors;
  int   pending;
  int   cycles = 0;
  bit   no_idle = 1'b0;
  bit   hold = 1'b0;
  bit   hold_start = 1'b0;
  int   loaded_list[$];
  logic [31:0] center_x, center_y, center_z, spread;

  xsph_velocity_smoothing u_dut (
    .clk, .rst, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item,
    .cfg_we, .cfg_index, .cfg_data
  );

  xsph_smoothing_checker u_check (
    .clk, .rst, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item,
    .cfg_we, .cfg_index, .cfg_data, .errors, .pending
  );

  always #10 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stalls unless quiet, never ready during a hold-off
  always @(posedge clk) begin
    if (hold) out_ready <= 1'b0;
    else out_ready <= no_idle || ($urandom_range(99) >= 13);
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_start);
    @(posedge clk);
    hold <= 1'b1;
    repeat (2500) @(posedge clk);
    hold <= 1'b0;
  end

  // Offer one item, with random gaps ahead of it, and wait until it is taken
  task automatic send_item(input in_item_t it);
    while (!no_idle && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic in_item_t junk_item(input logic [1:0] k, input int p, input int n);
    in_item_t it;
    it.kind = k;
    it.particle_index = p[11:0];
    it.neighbor_index = n[11:0];
    it.pos_x = $urandom; it.pos_y = $urandom; it.pos_z = $urandom;
    it.vel_x = $urandom; it.vel_y = $urandom; it.vel_z = $urandom;
    return it;
  endfunction

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(255) - 128;
      default: return $urandom;
    endcase
  endfunction

  // Load one particle near the current cluster center
  task automatic load_particle(input int idx);
    in_item_t it;
    it = junk_item(KIND_LOAD, idx, $urandom_range(4095));
    it.pos_x = center_x + ($urandom & spread);
    it.pos_y = center_y + ($urandom & spread);
    it.pos_z = center_z + ($urandom & spread);
    it.vel_x = rand_vel(); it.vel_y = rand_vel(); it.vel_z = rand_vel();
    send_item(it);
    loaded_list.push_back(idx);
  endtask

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(loaded_list.size() - 1)];
  endfunction

  // Drain results and let the block go idle, then write one register
  task automatic write_reg(input logic [1:0] idx, input logic [61:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input logic [17:0] g, input logic [61:0] r, input logic [47:0] v);
    write_reg(CFG_GAIN, 62'(g));
    write_reg(CFG_RADIUS_SQ, r);
    write_reg(CFG_INV_RSQ, 62'(v));
  endtask

  // One particle: a neighbor list, now and then broken or overlong, then finish
  task automatic smooth_one(inout int sent);
    int p, nn;
    p = pick_loaded();
    nn = ($urandom_range(15) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 12);
    for (int i = 0; i < nn; i++) begin
      case ($urandom_range(29))
        0: send_item(junk_item(KIND_SPARE, $urandom_range(4095), $urandom_range(4095)));
        1: load_particle($urandom_range(4095));
        2: send_item(junk_item(KIND_NEIGH, p, p));
        default: send_item(junk_item(KIND_NEIGH, p, pick_loaded()));
      endcase
      sent++;
    end
    if ($urandom_range(19) != 0) begin
      send_item(junk_item(KIND_FINISH, p, $urandom_range(4095)));
      sent++;
    end
  endtask

  // Fresh cluster of particles, then random smoothing up to the budget
  task automatic run_phase(input int budget, input logic [31:0] mask);
    int sent;
    sent = 0;
    center_x = $urandom; center_y = $urandom; center_z = $urandom;
    spread = mask;
    for (int i = 0; i < 20; i++) begin
      load_particle($urandom_range(4095));
      sent++;
    end
    while (sent < budget) smooth_one(sent);
  endtask

  initial begin
    in_item_t it;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme indices and velocities, self, far and near neighbors
    set_regs(18'd65536, 62'd1 << 40, 48'd1 << 24);
    center_x = 32'h1000_0000; center_y = 32'hF000_0000; center_z = '0;
    spread = 32'h0000_FFFF;
    it = junk_item(KIND_LOAD, 0, 4095);
    it.pos_x = center_x; it.pos_y = center_y; it.pos_z = center_z;
    it.vel_x = 32'h7FFF_FFFF; it.vel_y = 32'h8000_0000; it.vel_z = 32'h0;
    send_item(it);
    loaded_list.push_back(0);
    it = junk_item(KIND_LOAD, 4095, 0);
    it.pos_x = center_x + 32'h100; it.pos_y = center_y; it.pos_z = center_z - 32'h100;
    it.vel_x = 32'h8000_0000; it.vel_y = 32'h7FFF_FFFF; it.vel_z = 32'hFFFF_FFFF;
    send_item(it);
    loaded_list.push_back(4095);
    it = junk_item(KIND_LOAD, 1, 0);
    it.pos_x = 32'h8000_0000; it.pos_y = 32'h7FFF_FFFF;
    send_item(it);
    loaded_list.push_back(1);
    load_particle(2);
    send_item(junk_item(KIND_NEIGH, 0, 0));
    send_item(junk_item(KIND_NEIGH, 0, 4095));
    send_item(junk_item(KIND_NEIGH, 0, 1));
    send_item(junk_item(KIND_NEIGH, 0, 2));
    send_item(junk_item(KIND_FINISH, 0, 0));
    // zero weight total: finish with no neighbors
    send_item(junk_item(KIND_FINISH, 1, 4095));
    send_item(junk_item(KIND_SPARE, 4095, 4095));
    send_item(junk_item(KIND_NEIGH, 4095, 0));
    send_item(junk_item(KIND_FINISH, 4095, 0));

    // Random phases over several register settings; hold-off in the first
    hold_start = 1'b1;
    run_phase(380, 32'h000F_FFFF);
    set_regs(18'h3FFFF, 62'h3FFF_FFFF_FFFF_FFFF, 48'd4);
    no_idle = 1'b1;
    run_phase(380, 32'hFFFF_FFFF);
    no_idle = 1'b0;
    set_regs(18'd0, 62'd0, 48'hFFFF_FFFF_FFFF);
    run_phase(380, 32'h0000_0003);
    set_regs(18'($urandom), 62'({$urandom, $urandom} >> $urandom_range(2, 40)),
             48'({$urandom, $urandom}));
    run_phase(380, $urandom >> $urandom_range(0, 31));
    set_regs(18'd1, 62'd1 << 30, 48'd1 << 34);
    run_phase(380, 32'h0000_3FFF);

    // Drain and finish
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
